@@ rtl/core/arf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arf_pkg: shared types and constants of the alignment record filter
// Character codes, saturation limits, verdict codes and the line summary
// handed from the parser to the result stage.
// ----------------------------------------------------------------------------
package arf_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned MarginW = 16;
  localparam int unsigned FlagW   = 16;
  localparam int unsigned SumW    = 31;
  localparam int unsigned FieldW  = 3;

  localparam logic [ChW-1:0] ChNewline = 8'd10;
  localparam logic [ChW-1:0] ChTab     = 8'd9;
  localparam logic [ChW-1:0] ChHeader  = 8'h40; // '@'
  localparam logic [ChW-1:0] ChMatch   = 8'h4d; // 'M'
  localparam logic [ChW-1:0] ChZero    = 8'h30; // '0'
  localparam logic [ChW-1:0] ChNine    = 8'h39; // '9'

  localparam logic [MarginW-1:0] MarginReset = 16'd20;
  localparam logic [FlagW-1:0]   FlagMax     = 16'hffff;
  localparam logic [FlagW-1:0]   FlagDropMin = 16'd256;
  localparam logic [SumW-1:0]    SumMax      = 31'h7fffffff;
  localparam logic [FieldW-1:0]  FieldMax    = 3'd7;
  localparam logic [FieldW-1:0]  FieldFlag   = 3'd1;
  localparam logic [FieldW-1:0]  FieldOps    = 3'd5;

  typedef enum logic [2:0] {
    VERDICT_HEADER    = 3'd0,
    VERDICT_SECONDARY = 3'd1,
    VERDICT_UNPAIRED  = 3'd2,
    VERDICT_SHORT     = 3'd3,
    VERDICT_FULL      = 3'd4,
    VERDICT_MALFORMED = 3'd5
  } verdict_e;

  // Verdict for the line as it stands, valid when a newline arrives
  typedef struct packed {
    logic            keep;
    verdict_e        verdict;
    logic [SumW-1:0] match_total;
    logic [SumW-1:0] length_total;
  } line_result_t;

endpackage

@@ rtl/core/alignment_record_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alignment_record_filter: keep-or-drop filter for alignment text lines
// Consumes one text byte per item and gives one verdict item per line.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: ch_i with in_valid_i / in_stall_o, one byte per item.
//   Output channel: keep_o, verdict_o, match_total_o, length_total_o with
//   out_valid_o / out_stall_i; one item for each newline byte, none else.
//   Throughput: one input byte per cycle while in_stall_o is low.
//   Latency: the verdict item appears the cycle after its newline is taken;
//   it is computed from the registered line state and lands in a single
//   output register.
//   Stall: while an output item waits under out_stall_i the block keeps
//   taking bytes; it raises in_stall_o only for a newline that meets the
//   held item, so a newline never overwrites an untaken verdict.
//   Configuration: cfg_we_i writes cfg_data_i into the match margin; write
//   only with the block idle.
//   Reset: clears the line state (start of line, no fields), empties the
//   output register and sets the margin to 20.
// ----------------------------------------------------------------------------
module alignment_record_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [arf_pkg::MarginW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [arf_pkg::ChW-1:0]      ch_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         keep_o,
  output logic [2:0]                   verdict_o,
  output logic [arf_pkg::SumW-1:0]     match_total_o,
  output logic [arf_pkg::SumW-1:0]     length_total_o
);
  import arf_pkg::*;

  logic [MarginW-1:0] margin_q;
  logic               accept;
  line_result_t       line_res;
  line_result_t       res_q;
  logic               out_valid_q, out_valid_d;

  // Hold off a newline only while an output item is stuck
  assign in_stall_o = out_valid_q && out_stall_i && (ch_i == ChNewline);
  assign accept     = in_valid_i && !in_stall_o;

  arf_line_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (ch_i),
    .margin_i (margin_q),
    .result_o (line_res)
  );

  // Margin register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MarginReset;
    end else if (cfg_we_i) begin
      margin_q <= cfg_data_i;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (accept && ch_i == ChNewline) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && ch_i == ChNewline) begin
      res_q <= line_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign keep_o         = res_q.keep;
  assign verdict_o      = res_q.verdict;
  assign match_total_o  = res_q.match_total;
  assign length_total_o = res_q.length_total;

  // Checks
  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with no output item held");

  a_newline_gives_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ch_i == ChNewline) |=> out_valid_q)
    else $error("newline accepted but no output item");

  a_keep_matches_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (keep_o == !(res_q.verdict == VERDICT_SECONDARY ||
                                 res_q.verdict == VERDICT_FULL)))
    else $error("keep flag disagrees with verdict");

  a_totals_only_for_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !(res_q.verdict == VERDICT_SHORT || res_q.verdict == VERDICT_FULL))
      |-> (match_total_o == '0 && length_total_o == '0))
    else $error("totals set for a verdict without operation field");

  a_short_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.verdict == VERDICT_SHORT) |-> (match_total_o < length_total_o))
    else $error("short match verdict with match total not below length");

endmodule

@@ rtl/core/arf_line_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arf_line_parser: per-character line state and verdict logic
// Tracks fields, the decimal flag and the operation run sums of one line,
// and presents the verdict of the line so far for the newline item.
// ----------------------------------------------------------------------------
module arf_line_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [arf_pkg::ChW-1:0]      ch_i,
  input  logic [arf_pkg::MarginW-1:0]  margin_i,
  output arf_pkg::line_result_t        result_o
);
  import arf_pkg::*;

  logic [FieldW-1:0] field_idx_q, field_idx_d;
  logic              field_open_q, field_open_d;
  logic              line_start_q, line_start_d;
  logic              header_q, header_d;
  logic [FlagW-1:0]  flag_q, flag_d;
  logic              flag_done_q, flag_done_d;
  logic [SumW-1:0]   run_q, run_d;
  logic [SumW-1:0]   len_sum_q, len_sum_d;
  logic [SumW-1:0]   match_sum_q, match_sum_d;

  logic              is_digit;
  logic [3:0]        digit;
  logic [FlagW+3:0]  flag_ext;
  logic [SumW+3:0]   run_ext;
  logic [SumW:0]     len_add;
  logic [SumW:0]     match_add;
  logic              has_f1;
  logic              has_f5;
  logic [SumW:0]     match_plus_margin;

  // Character decode and saturating arithmetic
  always_comb begin
    is_digit  = (ch_i >= ChZero) && (ch_i <= ChNine);
    digit     = 4'(ch_i - ChZero);
    flag_ext  = {1'b0, flag_q, 3'b000} + {3'b000, flag_q, 1'b0} + {16'd0, digit};
    run_ext   = {1'b0, run_q, 3'b000} + {3'b000, run_q, 1'b0} + {31'd0, digit};
    len_add   = {1'b0, len_sum_q} + {1'b0, run_q};
    match_add = {1'b0, match_sum_q} + {1'b0, run_q};
  end

  // Next-state logic for one accepted item
  always_comb begin
    field_idx_d  = field_idx_q;
    field_open_d = field_open_q;
    line_start_d = line_start_q;
    header_d     = header_q;
    flag_d       = flag_q;
    flag_done_d  = flag_done_q;
    run_d        = run_q;
    len_sum_d    = len_sum_q;
    match_sum_d  = match_sum_q;
    if (accept_i) begin
      if (ch_i == ChNewline) begin
        field_idx_d  = '0;
        field_open_d = 1'b0;
        line_start_d = 1'b1;
        header_d     = 1'b0;
        flag_d       = '0;
        flag_done_d  = 1'b0;
        run_d        = '0;
        len_sum_d    = '0;
        match_sum_d  = '0;
      end else begin
        line_start_d = 1'b0;
        if (line_start_q && ch_i == ChHeader) begin
          header_d = 1'b1;
        end
        if (!(header_q || (line_start_q && ch_i == ChHeader))) begin
          if (ch_i == ChTab) begin
            if (field_open_q) begin
              field_open_d = 1'b0;
              if (field_idx_q != FieldMax) begin
                field_idx_d = field_idx_q + 3'd1;
              end
            end
          end else begin
            field_open_d = 1'b1;
            if (field_idx_q == FieldFlag) begin
              if (!flag_done_q) begin
                if (is_digit) begin
                  flag_d = (flag_ext > {4'd0, FlagMax}) ? FlagMax : flag_ext[FlagW-1:0];
                end else begin
                  flag_done_d = 1'b1;
                end
              end
            end else if (field_idx_q == FieldOps) begin
              if (is_digit) begin
                run_d = (run_ext > {4'd0, SumMax}) ? SumMax : run_ext[SumW-1:0];
              end else begin
                len_sum_d = len_add[SumW] ? SumMax : len_add[SumW-1:0];
                if (ch_i == ChMatch) begin
                  match_sum_d = match_add[SumW] ? SumMax : match_add[SumW-1:0];
                end
                run_d = '0;
              end
            end
          end
        end
      end
    end
  end

  // Verdict of the line so far
  always_comb begin
    has_f1 = (field_idx_q > FieldFlag) || (field_idx_q == FieldFlag && field_open_q);
    has_f5 = (field_idx_q > FieldOps) || (field_idx_q == FieldOps && field_open_q);
    match_plus_margin = {1'b0, match_sum_q} + {16'd0, margin_i};
    result_o.keep         = 1'b1;
    result_o.verdict      = VERDICT_HEADER;
    result_o.match_total  = '0;
    result_o.length_total = '0;
    if (header_q) begin
      result_o.verdict = VERDICT_HEADER;
    end else if (!has_f1) begin
      result_o.verdict = VERDICT_MALFORMED;
    end else if (flag_q >= FlagDropMin) begin
      result_o.keep    = 1'b0;
      result_o.verdict = VERDICT_SECONDARY;
    end else if (!flag_q[1]) begin
      result_o.verdict = VERDICT_UNPAIRED;
    end else if (!has_f5) begin
      result_o.verdict = VERDICT_MALFORMED;
    end else begin
      result_o.match_total  = match_sum_q;
      result_o.length_total = len_sum_q;
      if (match_plus_margin < {1'b0, len_sum_q}) begin
        result_o.verdict = VERDICT_SHORT;
      end else begin
        result_o.keep    = 1'b0;
        result_o.verdict = VERDICT_FULL;
      end
    end
  end

  // Line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_idx_q  <= '0;
      field_open_q <= 1'b0;
      line_start_q <= 1'b1;
      header_q     <= 1'b0;
      flag_q       <= '0;
      flag_done_q  <= 1'b0;
      run_q        <= '0;
      len_sum_q    <= '0;
      match_sum_q  <= '0;
    end else begin
      field_idx_q  <= field_idx_d;
      field_open_q <= field_open_d;
      line_start_q <= line_start_d;
      header_q     <= header_d;
      flag_q       <= flag_d;
      flag_done_q  <= flag_done_d;
      run_q        <= run_d;
      len_sum_q    <= len_sum_d;
      match_sum_q  <= match_sum_d;
    end
  end

endmodule
